[hw/rtl/rikl_pkg.sv]
// ----------------------------------------------------------------------------
// rikl_pkg
// Shared constants, codes and controller/datapath interface types for the
// range insert / k-th largest unit.
// ----------------------------------------------------------------------------
package rikl_pkg;

  // Default sizing of the count store
  localparam int POSITIONS_DEF  = 64;
  localparam int VALUES_DEF     = 64;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int FIELD_W = 7;
  localparam int K_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Reset value of both configuration registers before clamping
  localparam int CFG_RESET = 64;

  // Item commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT    = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture input beat, start a walk
    logic clr_step; // write zero at clear address, advance
    logic rd;       // read cell at (p, v)
    logic ins_wr;   // write saturated increment at (p, v)
    logic acc;      // add read data to the running total
    logic p_next;   // next position
    logic v_next;   // next lower value rank, restart position
    logic out_set;  // load the result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic query;
    logic skip;
    logic p_last;
    logic v_last;
    logic hit;
    logic out_free;
  } ctl_stat_t;

endpackage

[hw/rtl/range_insert_kth_largest_unit.sv]
// ----------------------------------------------------------------------------
// range_insert_kth_largest_unit
// Range insert / k-th largest query over a saturating count store of
// value rank by position.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the count store to zero, one cell per cycle;
// in_ready stays low until the sweep ends, configuration writes are taken
// throughout. One beat is worked at a time, each cell visit a read, then a
// write or accumulate, on the single count RAM (registered read). Beats
// that clip to an empty range, insert a bad rank, or ask for k of zero
// finish without visiting any cell. A result sits in an output register,
// and the unit accepts the next beat while it waits to be taken.
// ----------------------------------------------------------------------------
module range_insert_kth_largest_unit #(
  parameter int POSITIONS  = rikl_pkg::POSITIONS_DEF,
  parameter int VALUES     = rikl_pkg::VALUES_DEF,
  parameter int COUNT_BITS = rikl_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rikl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rikl_pkg::FIELD_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [rikl_pkg::FIELD_W-1:0]   left_position,
  input  logic [rikl_pkg::FIELD_W-1:0]   right_position,
  input  logic [rikl_pkg::FIELD_W-1:0]   value_rank,
  input  logic [rikl_pkg::K_W-1:0]       rank_wanted,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic [rikl_pkg::FIELD_W-1:0]   result_rank
);

  rikl_pkg::ctl_cmd_t  ctl;
  rikl_pkg::ctl_stat_t stat;

  // Sequencer
  rikl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  // Datapath with count store
  rikl_dp #(
    .POSITIONS  (POSITIONS),
    .VALUES     (VALUES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .left_position  (left_position),
    .right_position (right_position),
    .value_rank     (value_rank),
    .rank_wanted    (rank_wanted),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .result_rank    (result_rank)
  );

endmodule

[hw/rtl/rikl_ram.sv]
// ----------------------------------------------------------------------------
// rikl_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rikl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rikl_ctrl.sv]
// ----------------------------------------------------------------------------
// rikl_ctrl
// Sequencer: clearing pass after reset, then per beat a walk over the count
// store (positions inner, value ranks outer from the top down).
// ----------------------------------------------------------------------------
module rikl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output rikl_pkg::ctl_cmd_t  ctl,
  input  rikl_pkg::ctl_stat_t stat
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_USE   = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.skip) begin
          state_next = stat.query ? S_DONE : S_IDLE;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_USE;
      end
      S_USE: begin
        ctl.ins_wr = !stat.query;
        ctl.acc    = stat.query;
        if (stat.p_last) begin
          state_next = stat.query ? S_CHECK : S_IDLE;
        end else begin
          ctl.p_next = 1'b1;
          state_next = S_RD;
        end
      end
      S_CHECK: begin
        if (stat.hit || stat.v_last) begin
          state_next = S_DONE;
        end else begin
          ctl.v_next = 1'b1;
          state_next = S_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.out_set = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/rikl_dp.sv]
// ----------------------------------------------------------------------------
// rikl_dp
// Datapath: configuration registers, captured beat, walk counters, running
// total, count store and result register.
// ----------------------------------------------------------------------------
module rikl_dp #(
  parameter int POSITIONS  = rikl_pkg::POSITIONS_DEF,
  parameter int VALUES     = rikl_pkg::VALUES_DEF,
  parameter int COUNT_BITS = rikl_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rikl_pkg::ctl_cmd_t                   ctl,
  output rikl_pkg::ctl_stat_t                  stat,
  input  logic                                 cfg_write,
  input  logic [rikl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rikl_pkg::FIELD_W-1:0]         cfg_data,
  input  logic                                 cmd,
  input  logic [rikl_pkg::FIELD_W-1:0]         left_position,
  input  logic [rikl_pkg::FIELD_W-1:0]         right_position,
  input  logic [rikl_pkg::FIELD_W-1:0]         value_rank,
  input  logic [rikl_pkg::K_W-1:0]             rank_wanted,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 found,
  output logic [rikl_pkg::FIELD_W-1:0]         result_rank
);

  localparam int FW    = rikl_pkg::FIELD_W;
  localparam int DEPTH = POSITIONS * VALUES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = AW + COUNT_BITS + 1;
  localparam int CW    = (TW > rikl_pkg::K_W) ? TW : rikl_pkg::K_W;
  localparam logic [FW-1:0] PC_RESET =
    (POSITIONS < rikl_pkg::CFG_RESET) ? FW'(POSITIONS) : FW'(rikl_pkg::CFG_RESET);
  localparam logic [FW-1:0] VC_RESET =
    (VALUES < rikl_pkg::CFG_RESET) ? FW'(VALUES) : FW'(rikl_pkg::CFG_RESET);

  // Clamp a register write to [1, top]
  function automatic logic [FW-1:0] clamp_reg(input logic [FW-1:0] val, input int top);
    logic [FW-1:0] res;
    if (val == '0) begin
      res = FW'(1);
    end else if (32'(val) > top) begin
      res = FW'(top);
    end else begin
      res = val;
    end
    return res;
  endfunction

  logic [FW-1:0]         position_count;
  logic [FW-1:0]         value_count;
  logic                  cmd_q;
  logic                  skip;
  logic [FW-1:0]         lo;
  logic [FW-1:0]         hi;
  logic [rikl_pkg::K_W-1:0] k;
  logic [FW-1:0]         p;
  logic [FW-1:0]         v;
  logic [TW-1:0]         total;
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] inc_data;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [FW-1:0]         lo_c;
  logic [FW-1:0]         hi_c;
  logic                  skip_c;
  logic                  hit;
  logic                  found_c;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= PC_RESET;
      value_count    <= VC_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rikl_pkg::REG_POSITION_COUNT: position_count <= clamp_reg(cfg_data, POSITIONS);
        rikl_pkg::REG_VALUE_COUNT:    value_count    <= clamp_reg(cfg_data, VALUES);
        default: ;
      endcase
    end
  end

  // Range clip and trivial-beat check on the incoming beat
  always_comb begin
    lo_c   = (left_position == '0) ? FW'(1) : left_position;
    hi_c   = (right_position > position_count) ? position_count : right_position;
    skip_c = (lo_c > hi_c);
    if (cmd == rikl_pkg::CMD_INSERT) begin
      if (value_rank == '0 || value_rank > value_count) skip_c = 1'b1;
    end else begin
      if (rank_wanted == '0) skip_c = 1'b1;
    end
  end

  // Captured beat, walk counters and running total
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      skip  <= skip_c;
      lo    <= lo_c;
      hi    <= hi_c;
      k     <= rank_wanted;
      p     <= lo_c;
      v     <= (cmd == rikl_pkg::CMD_INSERT) ? value_rank : value_count;
      total <= '0;
    end else begin
      if (ctl.p_next) p <= p + FW'(1);
      if (ctl.v_next) begin
        v <= v - FW'(1);
        p <= lo;
      end
      if (ctl.acc) total <= total + TW'(rd_data);
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Cell address of (p, v); inserts walk with v set to the inserted rank
  assign addr = AW'((32'(p) - 1) * VALUES + (32'(v) - 1));

  // Saturating increment
  assign inc_data = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + COUNT_BITS'(1);

  // Write port mux
  assign ram_we    = ctl.clr_step | ctl.ins_wr;
  assign ram_waddr = ctl.clr_step ? clr_addr : addr;
  assign ram_wdata = ctl.clr_step ? '0 : inc_data;

  rikl_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign hit     = (CW'(total) >= CW'(k));
  assign found_c = !skip && hit;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_set) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_set) begin
      found       <= found_c;
      result_rank <= found_c ? v : '0;
    end
  end

  // Status to the controller
  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_addr == AW'(DEPTH - 1));
    stat.query    = (cmd_q == rikl_pkg::CMD_QUERY);
    stat.skip     = skip;
    stat.p_last   = (p == hi);
    stat.v_last   = (v == FW'(1));
    stat.hit      = hit;
    stat.out_free = !out_valid || out_ready;
  end

endmodule
